FILE: sv/mp2d_pkg.sv
`default_nettype none

package mp2d_pkg;

  // Default sizes
  localparam int unsigned MAX_COLS_DEF   = 1024;
  localparam int unsigned MAX_POOL_DEF   = 8;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned POOL_W      = 4;   // pool size and stride registers
  localparam int unsigned FRAME_W     = 11;  // frame_cols / frame_rows registers
  localparam int unsigned ROW_W       = 10;  // input row counter
  localparam int unsigned ROW_LIMIT   = 1024;
  localparam int unsigned IDX_W       = 10;  // output row / column index
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_WIDTH  = 3'd0,
    CFG_POOL_HEIGHT = 3'd1,
    CFG_STRIDE_X    = 3'd2,
    CFG_STRIDE_Y    = 3'd3,
    CFG_FRAME_COLS  = 3'd4,
    CFG_FRAME_ROWS  = 3'd5
  } cfg_reg_e;

  // Window engine states
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_EMIT
  } back_state_e;

  // Per-pixel job description handed from front to back
  typedef struct packed {
    logic              win;        // pixel closes a window
    logic              plane_end;  // last window of the plane
    logic [POOL_W-1:0] pw;
    logic [POOL_W-1:0] ph;
    logic [IDX_W-1:0]  orow;
    logic [IDX_W-1:0]  ocol;
  } job_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/mp2d_ram.sv
`default_nettype none

module mp2d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/mp2d_fifo.sv
`default_nettype none

module mp2d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = mp2d_pkg::QUEUE_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots[rptr_q];

  // Pointer and fill tracking
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mp2d_front.sv
`default_nettype none

module mp2d_front #(
  parameter int unsigned MAX_COLS = mp2d_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_POOL = mp2d_pkg::MAX_POOL_DEF,
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned SW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1,
  localparam int unsigned AW = (MAX_POOL * MAX_COLS > 1) ? $clog2(MAX_POOL * MAX_COLS) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              push_i,
  input  wire logic                              full_i,
  output logic                                   enq_o,
  output mp2d_pkg::job_ctrl_t                    ctrl_o,
  output logic [AW-1:0]                          waddr_o,
  output logic [CW-1:0]                          col0_o,
  output logic [SW-1:0]                          slot0_o
);

  localparam int unsigned PW_ = mp2d_pkg::POOL_W;
  localparam int unsigned XW  = ((CW > PW_) ? CW : PW_) + 2;  // column arithmetic
  localparam int unsigned RXW = mp2d_pkg::ROW_W + 2;          // row arithmetic
  localparam int unsigned SLW = ((SW > PW_) ? SW : PW_) + 1;  // slot arithmetic

  // Configuration registers
  logic [PW_-1:0]                 pool_w_q, pool_h_q, stride_x_q, stride_y_q;
  logic [mp2d_pkg::FRAME_W-1:0]   frame_cols_q, frame_rows_q;
  logic                           cfg_hit;

  // Position counters
  logic [CW-1:0]                  col_q, col_d;
  logic [mp2d_pkg::ROW_W-1:0]     row_q, row_d;
  logic [SW-1:0]                  slot_q, slot_d;
  logic [PW_-1:0]                 cph_q, cph_d, rph_q, rph_d;
  logic [mp2d_pkg::IDX_W-1:0]     ocol_q, ocol_d, orow_q, orow_d;

  // Effective sizes
  logic [PW_-1:0] pw, ph, sx, sy;
  logic [XW-1:0]  cols, c1;
  logic [RXW-1:0] rows, r1;
  logic           col_ok, row_ok, row_end, plane_wrap;
  logic [SLW-1:0] s_ext, p_ext;

  function automatic logic [PW_-1:0] clamp_pool(input logic [PW_-1:0] v);
    logic [PW_-1:0] r;
    r = v;
    if (v == '0) begin
      r = PW_'(1);
    end else if ({1'b0, v} > (PW_ + 1)'(MAX_POOL)) begin
      r = PW_'(MAX_POOL);
    end
    return r;
  endfunction

  // Decode of a configuration write
  always_comb begin
    case (cfg_idx_i)
      mp2d_pkg::CFG_POOL_WIDTH,
      mp2d_pkg::CFG_POOL_HEIGHT,
      mp2d_pkg::CFG_STRIDE_X,
      mp2d_pkg::CFG_STRIDE_Y,
      mp2d_pkg::CFG_FRAME_COLS,
      mp2d_pkg::CFG_FRAME_ROWS: cfg_hit = cfg_we_i;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_w_q     <= PW_'(2);
      pool_h_q     <= PW_'(2);
      stride_x_q   <= PW_'(2);
      stride_y_q   <= PW_'(2);
      frame_cols_q <= mp2d_pkg::FRAME_W'(1024);
      frame_rows_q <= mp2d_pkg::FRAME_W'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mp2d_pkg::CFG_POOL_WIDTH:  pool_w_q     <= cfg_wdata_i[PW_-1:0];
        mp2d_pkg::CFG_POOL_HEIGHT: pool_h_q     <= cfg_wdata_i[PW_-1:0];
        mp2d_pkg::CFG_STRIDE_X:    stride_x_q   <= cfg_wdata_i[PW_-1:0];
        mp2d_pkg::CFG_STRIDE_Y:    stride_y_q   <= cfg_wdata_i[PW_-1:0];
        mp2d_pkg::CFG_FRAME_COLS:  frame_cols_q <= cfg_wdata_i;
        mp2d_pkg::CFG_FRAME_ROWS:  frame_rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Zero means one, oversize saturates
  always_comb begin
    pw = clamp_pool(pool_w_q);
    ph = clamp_pool(pool_h_q);
    sx = (stride_x_q == '0) ? PW_'(1) : stride_x_q;
    sy = (stride_y_q == '0) ? PW_'(1) : stride_y_q;
    if (frame_cols_q == '0) begin
      cols = XW'(1);
    end else if ({2'b00, frame_cols_q} > (mp2d_pkg::FRAME_W + 2)'(MAX_COLS)) begin
      cols = XW'(MAX_COLS);
    end else begin
      cols = XW'(frame_cols_q);
    end
    if (frame_rows_q == '0) begin
      rows = RXW'(1);
    end else if (frame_rows_q > mp2d_pkg::FRAME_W'(mp2d_pkg::ROW_LIMIT)) begin
      rows = RXW'(mp2d_pkg::ROW_LIMIT);
    end else begin
      rows = RXW'(frame_rows_q);
    end
  end

  // Classify the incoming pixel
  assign c1         = XW'(col_q) + 1'b1;
  assign r1         = RXW'(row_q) + 1'b1;
  assign col_ok     = (c1 >= XW'(pw));
  assign row_ok     = (r1 >= RXW'(ph));
  assign row_end    = (c1 >= cols);
  assign plane_wrap = row_end && (r1 >= rows);
  assign enq_o      = push_i && !full_i;

  assign s_ext = SLW'(slot_q);
  assign p_ext = SLW'(ph) - 1'b1;

  always_comb begin
    ctrl_o.win       = col_ok && row_ok && (cph_q == '0) && (rph_q == '0);
    ctrl_o.plane_end = ((r1 + RXW'(sy)) > rows) && ((c1 + XW'(sx)) > cols);
    ctrl_o.pw        = pw;
    ctrl_o.ph        = ph;
    ctrl_o.orow      = orow_q;
    ctrl_o.ocol      = ocol_q;
    col0_o           = CW'(c1 - XW'(pw));
    // slot of the window's top row, modulo the line count
    slot0_o          = (s_ext >= p_ext) ? SW'(s_ext - p_ext)
                                        : SW'(s_ext + SLW'(MAX_POOL) - p_ext);
    waddr_o          = AW'(slot_q) * AW'(MAX_COLS) + AW'(col_q);
  end

  // Counter advance per accepted pixel
  always_comb begin
    col_d  = col_q + 1'b1;
    row_d  = row_q;
    slot_d = slot_q;
    cph_d  = cph_q;
    ocol_d = ocol_q;
    rph_d  = rph_q;
    orow_d = orow_q;
    if (col_ok) begin
      if (cph_q + 1'b1 == sx) begin
        cph_d  = '0;
        ocol_d = ocol_q + 1'b1;
      end else begin
        cph_d  = cph_q + 1'b1;
      end
    end
    if (row_end) begin
      col_d  = '0;
      cph_d  = '0;
      ocol_d = '0;
      row_d  = row_q + 1'b1;
      slot_d = (slot_q == SW'(MAX_POOL - 1)) ? '0 : slot_q + 1'b1;
      if (row_ok) begin
        if (rph_q + 1'b1 == sy) begin
          rph_d  = '0;
          orow_d = orow_q + 1'b1;
        end else begin
          rph_d  = rph_q + 1'b1;
        end
      end
      if (plane_wrap) begin
        row_d  = '0;
        slot_d = '0;
        rph_d  = '0;
        orow_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      cph_q  <= '0;
      ocol_q <= '0;
      rph_q  <= '0;
      orow_q <= '0;
    end else if (cfg_hit) begin
      // any register write restarts the plane
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      cph_q  <= '0;
      ocol_q <= '0;
      rph_q  <= '0;
      orow_q <= '0;
    end else if (enq_o) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
      cph_q  <= cph_d;
      ocol_q <= ocol_d;
      rph_q  <= rph_d;
      orow_q <= orow_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mp2d_back.sv
`default_nettype none

module mp2d_back #(
  parameter int unsigned MAX_COLS   = mp2d_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_POOL   = mp2d_pkg::MAX_POOL_DEF,
  parameter int unsigned PIXEL_BITS = mp2d_pkg::PIXEL_BITS_DEF,
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned SW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1,
  localparam int unsigned AW = (MAX_POOL * MAX_COLS > 1) ? $clog2(MAX_POOL * MAX_COLS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // job side
  input  wire logic                          job_valid_i,
  input  wire mp2d_pkg::job_ctrl_t           ctrl_i,
  input  wire logic [PIXEL_BITS-1:0]         pixel_i,
  input  wire logic [AW-1:0]                 waddr_i,
  input  wire logic [CW-1:0]                 col0_i,
  input  wire logic [SW-1:0]                 slot0_i,
  output logic                               job_pop_o,
  // result side
  input  wire logic                          pop_i,
  output logic                               empty_o,
  output logic [PIXEL_BITS-1:0]              max_value_o,
  output logic [mp2d_pkg::IDX_W-1:0]         out_row_o,
  output logic [mp2d_pkg::IDX_W-1:0]         out_col_o,
  output logic                               plane_end_o
);

  localparam int unsigned PW_ = mp2d_pkg::POOL_W;
  localparam logic [PIXEL_BITS-1:0] MIN_CODE = {1'b1, {(PIXEL_BITS - 1){1'b0}}};

  mp2d_pkg::back_state_e state_q, state_d;

  // Scan state
  logic [PW_-1:0]                pw_q, ph_q, i_q, j_q;
  logic [SW-1:0]                 slot_q;
  logic [CW-1:0]                 cbase_q, col_q;
  logic [mp2d_pkg::IDX_W-1:0]    orow_q, ocol_q;
  logic                          pend_q;
  logic [PIXEL_BITS-1:0]         best_q;
  logic                          rd_valid_q;

  // Result register
  logic                          out_valid_q;
  logic [PIXEL_BITS-1:0]         out_max_q;
  logic [mp2d_pkg::IDX_W-1:0]    out_row_q, out_col_q;
  logic                          out_pend_q;

  logic                          ram_we, ram_re, start, row_done, last_read, out_free, load_out;
  logic [AW-1:0]                 raddr;
  logic [PIXEL_BITS-1:0]         rdata;

  assign row_done  = (j_q == pw_q - 1'b1);
  assign last_read = row_done && (i_q == ph_q - 1'b1);
  assign out_free  = !out_valid_q || pop_i;
  assign raddr     = AW'(slot_q) * AW'(MAX_COLS) + AW'(col_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mp2d_pkg::B_IDLE:  if (job_valid_i && ctrl_i.win) state_d = mp2d_pkg::B_SCAN;
      mp2d_pkg::B_SCAN:  if (last_read) state_d = mp2d_pkg::B_DRAIN;
      mp2d_pkg::B_DRAIN: state_d = mp2d_pkg::B_EMIT;
      mp2d_pkg::B_EMIT:  if (out_free) state_d = mp2d_pkg::B_IDLE;
      default:           state_d = mp2d_pkg::B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    job_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      mp2d_pkg::B_IDLE: begin
        job_pop_o = job_valid_i;
        ram_we    = job_valid_i;
      end
      mp2d_pkg::B_SCAN:  ram_re = 1'b1;
      mp2d_pkg::B_DRAIN: ;
      mp2d_pkg::B_EMIT:  load_out = out_free;
      default: ;
    endcase
  end

  assign start = job_pop_o && ctrl_i.win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mp2d_pkg::B_IDLE;
      rd_valid_q <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= ram_re;
      if (start) begin
        i_q <= '0;
        j_q <= '0;
      end else if (ram_re) begin
        if (row_done) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

  // Window walk and running maximum
  always_ff @(posedge clk_i) begin
    if (start) begin
      pw_q    <= ctrl_i.pw;
      ph_q    <= ctrl_i.ph;
      slot_q  <= slot0_i;
      cbase_q <= col0_i;
      col_q   <= col0_i;
      orow_q  <= ctrl_i.orow;
      ocol_q  <= ctrl_i.ocol;
      pend_q  <= ctrl_i.plane_end;
      best_q  <= MIN_CODE;
    end else begin
      if (ram_re) begin
        if (row_done) begin
          col_q  <= cbase_q;
          slot_q <= (slot_q == SW'(MAX_POOL - 1)) ? '0 : slot_q + 1'b1;
        end else begin
          col_q  <= col_q + 1'b1;
        end
      end
      if (rd_valid_q && ($signed(rdata) > $signed(best_q))) begin
        best_q <= rdata;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_max_q  <= best_q;
      out_row_q  <= orow_q;
      out_col_q  <= ocol_q;
      out_pend_q <= pend_q;
    end
  end

  assign empty_o     = !out_valid_q;
  assign max_value_o = out_max_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign plane_end_o = out_pend_q;

  // Line store: one row slot per pooled line
  mp2d_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(MAX_POOL * MAX_COLS)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr_i),
    .wdata_i(pixel_i),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

`default_nettype wire

FILE: sv/max_pool_2d.sv
// Channel   Ports                                   Transaction
// --------  --------------------------------------  ---------------------------
// pixel in  push, full, pixel_value_i               push & !full at clk_i rise
// result    empty, pop, max_value_o, out_row_o,     pop & !empty at clk_i rise
//           out_col_o, plane_end_o
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i        cfg_we_i at clk_i rise
//
// A pixel that closes no window is only written to the line store; one that
// closes a window also has its pool_width * pool_height entries read back
// through the single read port of the line store, one entry per cycle.
// Reset clears front counters and loads the default registers; the line store
// is not cleared, every window reads only rows written in the current plane.
// A two-entry queue lets pixels land while a window is scanned; with pop low
// the engine keeps going until a second result needs the output register.
`default_nettype none

module max_pool_2d #(
  parameter int unsigned MAX_COLS   = mp2d_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_POOL   = mp2d_pkg::MAX_POOL_DEF,
  parameter int unsigned PIXEL_BITS = mp2d_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [PIXEL_BITS-1:0]           pixel_value_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [PIXEL_BITS-1:0]                max_value_o,
  output logic [mp2d_pkg::IDX_W-1:0]           out_row_o,
  output logic [mp2d_pkg::IDX_W-1:0]           out_col_o,
  output logic                                 plane_end_o
);

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned SW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int unsigned AW = (MAX_POOL * MAX_COLS > 1) ? $clog2(MAX_POOL * MAX_COLS) : 1;
  localparam int unsigned CTW = $bits(mp2d_pkg::job_ctrl_t);
  localparam int unsigned JW = CTW + PIXEL_BITS + AW + CW + SW;

  mp2d_pkg::job_ctrl_t   f_ctrl, b_ctrl;
  logic [AW-1:0]         f_waddr, b_waddr;
  logic [CW-1:0]         f_col0, b_col0;
  logic [SW-1:0]         f_slot0, b_slot0;
  logic [PIXEL_BITS-1:0] b_pixel;
  logic                  enq, q_empty, q_pop;
  logic [JW-1:0]         q_in, q_out;

  // Front: counters, registers and pixel classification
  mp2d_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_POOL(MAX_POOL)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .full_i     (full),
    .enq_o      (enq),
    .ctrl_o     (f_ctrl),
    .waddr_o    (f_waddr),
    .col0_o     (f_col0),
    .slot0_o    (f_slot0)
  );

  assign q_in = {f_ctrl, pixel_value_i, f_waddr, f_col0, f_slot0};

  // Job queue between front and window engine
  mp2d_fifo #(
    .WIDTH(JW),
    .DEPTH(mp2d_pkg::QUEUE_DEPTH)
  ) u_job_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (enq),
    .data_i (q_in),
    .full_o (full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  assign {b_ctrl, b_pixel, b_waddr, b_col0, b_slot0} = q_out;

  // Back: line store write, window scan, result register
  mp2d_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_POOL  (MAX_POOL),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!q_empty),
    .ctrl_i     (b_ctrl),
    .pixel_i    (b_pixel),
    .waddr_i    (b_waddr),
    .col0_i     (b_col0),
    .slot0_i    (b_slot0),
    .job_pop_o  (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .max_value_o(max_value_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .plane_end_o(plane_end_o)
  );

endmodule

`default_nettype wire

FILE: sv/mp2d_checker.sv
`default_nettype none

module mp2d_checker #(
  parameter int unsigned PIXEL_BITS = mp2d_pkg::PIXEL_BITS_DEF
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    push,
  input wire logic                    full,
  input wire logic                    empty,
  input wire logic                    pop,
  input wire logic [PIXEL_BITS-1:0]   max_value_o,
  input wire logic [mp2d_pkg::IDX_W-1:0] out_row_o,
  input wire logic [mp2d_pkg::IDX_W-1:0] out_col_o,
  input wire logic                    plane_end_o
);

  // Under reset nothing is queued and no result is shown
  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queue or result register not cleared by reset");

  // A waiting result stays put until it is taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(max_value_o) && $stable(out_row_o)
                          && $stable(out_col_o) && $stable(plane_end_o)))
    else $error("pending result changed before pop");

  // The job queue only fills up through an accepted pixel
  a_full_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted pixel");

endmodule

bind max_pool_2d mp2d_checker #(
  .PIXEL_BITS(PIXEL_BITS)
) u_mp2d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .max_value_o(max_value_o),
  .out_row_o  (out_row_o),
  .out_col_o  (out_col_o),
  .plane_end_o(plane_end_o)
);

`default_nettype wire
